>>> rtl/core/oaids_pkg.sv
package oaids_pkg;

    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int GRP    = 8;

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_SEARCH = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_INVALID   = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_PICK_A,
        ST_PICK_B,
        ST_OUT
    } state_t;

    // Broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic              step;
        logic              shift_up;
        logic              shift_down;
        logic              by_value;
        logic              by_index;
        logic [POS_W-1:0]  boundary;
        logic [POS_W-1:0]  count;
        logic [DATA_W-1:0] key;
    } cell_ctrl_t;

endpackage

>>> rtl/core/ordered_array_insert_delete_search.sv
// Positional list of up to DEPTH signed 32-bit values held in a row of cells.
// Input channel (s_): s_tuser carries the request kind (read, insert, delete,
// search); s_tdata carries the 1-based position and the value. Result channel
// (m_): m_tuser carries the status; m_tdata carries the found position, the
// read value and the element count after the request. Every request gives
// exactly one result transfer.
// Each request passes these steps between its input transfer and its result:
// it is latched, every cell shifts or compares at once, the registered
// first-match tree (groups of eight cells, then the groups) that serves
// search and read picks its result, and the output register is loaded.
// The next request is taken only once that sequence has returned to idle, so
// the block does not take a new request before the last result is loaded.
// A result waiting in the output register does not block the next input
// transfer; a new result loads unless one is held and m_tready is low.
// Reset (aresetn low at a clock edge) empties the list and drops m_tvalid.
// Stored values are not cleared; positions beyond the count are never read.
module ordered_array_insert_delete_search
    import oaids_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // mode
    input  logic [39:0] s_tdata,   // position [6:0], value [38:7], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // status
    output logic [47:0] m_tdata    // found_position [6:0], read_value [38:7],
                                   // element_count [45:39], zero fill
);

    localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
    localparam int NLEAF = NGRP * GRP;

    state_t state_reg, state_next;

    mode_t                    req_mode_reg;
    logic [POS_W-1:0]         req_pos_reg;
    logic [DATA_W-1:0]        req_value_reg;
    status_t                  status_reg;
    logic [POS_W-1:0]         count_reg, count_next;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [POS_W-1:0]         out_fpos_reg;
    logic signed [DATA_W-1:0] out_rval_reg;
    logic [POS_W-1:0]         out_count_reg;

    logic       s_xfer;
    logic       out_load;
    logic       pos_in_list;
    logic       pos_insertable;
    logic       list_full;
    status_t    status_next;
    cell_ctrl_t ctrl;

    logic [DATA_W-1:0] cell_data  [DEPTH];
    logic              cell_match [DEPTH];

    logic              leaf_hit  [NLEAF];
    logic [POS_W-1:0]  leaf_pos  [NLEAF];
    logic [DATA_W-1:0] leaf_data [NLEAF];

    logic              grp_hit  [NGRP];
    logic [POS_W-1:0]  grp_pos  [NGRP];
    logic [DATA_W-1:0] grp_data [NGRP];

    logic              fin_hit;
    logic [POS_W-1:0]  fin_pos;
    logic [DATA_W-1:0] fin_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    // Range checks against the count before the request.
    assign pos_in_list    = (req_pos_reg != '0) && (req_pos_reg <= count_reg);
    assign pos_insertable = (req_pos_reg != '0)
                         && (req_pos_reg <= POS_W'(count_reg + POS_W'(1)));
    assign list_full      = (count_reg == POS_W'(DEPTH));

    always_comb begin
        status_next = STATUS_OK;
        count_next  = count_reg;
        unique case (req_mode_reg)
            MODE_READ: begin
                status_next = pos_in_list ? STATUS_OK : STATUS_INVALID;
            end
            MODE_INSERT: begin
                if (!pos_insertable) begin
                    status_next = STATUS_INVALID;
                end else if (list_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = POS_W'(count_reg + POS_W'(1));
                end
            end
            MODE_DELETE: begin
                if (pos_in_list) begin
                    count_next = POS_W'(count_reg - POS_W'(1));
                end else begin
                    status_next = STATUS_INVALID;
                end
            end
            MODE_SEARCH: begin
                status_next = STATUS_NOT_FOUND;
            end
            default: begin
                status_next = STATUS_INVALID;
            end
        endcase
    end

    always_comb begin
        ctrl.step       = (state_reg == ST_CELL);
        ctrl.shift_up   = (req_mode_reg == MODE_INSERT) && pos_insertable && !list_full;
        ctrl.shift_down = (req_mode_reg == MODE_DELETE) && pos_in_list;
        ctrl.by_value   = (req_mode_reg == MODE_SEARCH);
        ctrl.by_index   = (req_mode_reg == MODE_READ);
        ctrl.boundary   = POS_W'(req_pos_reg - POS_W'(1));
        ctrl.count      = count_reg;
        ctrl.key        = req_value_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_xfer) state_next = ST_CELL;
            ST_CELL:   state_next = ST_PICK_A;
            ST_PICK_A: state_next = ST_PICK_B;
            ST_PICK_B: state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CELL) begin
                count_reg <= count_next;
            end
        end
    end

    // Request and per-request status; payload, so no reset.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_mode_reg  <= mode_t'(s_tuser);
            req_pos_reg   <= s_tdata[6:0];
            req_value_reg <= s_tdata[38:7];
        end
        if (state_reg == ST_CELL) begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_count_reg <= count_reg;
            out_fpos_reg  <= '0;
            out_rval_reg  <= '0;
            if (req_mode_reg == MODE_SEARCH) begin
                out_status_reg <= fin_hit ? STATUS_OK : STATUS_NOT_FOUND;
                out_fpos_reg   <= fin_hit ? fin_pos : '0;
            end else begin
                out_status_reg <= status_reg;
                if (req_mode_reg == MODE_READ && status_reg == STATUS_OK) begin
                    out_rval_reg <= fin_data;
                end
            end
        end
    end

    // The row of cells; the ends see zero from outside.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] left_w, right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_inner_l
            assign left_w = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_inner_r
            assign right_w = cell_data[i+1];
        end
        oaids_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .left_data (left_w),
            .right_data(right_w),
            .data_out  (cell_data[i]),
            .match_out (cell_match[i])
        );
    end

    // Leaves beyond the row never hit.
    for (genvar i = 0; i < NLEAF; i++) begin : g_leaf
        if (i < DEPTH) begin : g_used
            assign leaf_hit[i]  = cell_match[i];
            assign leaf_pos[i]  = POS_W'(i + 1);
            assign leaf_data[i] = cell_data[i];
        end else begin : g_pad
            assign leaf_hit[i]  = 1'b0;
            assign leaf_pos[i]  = '0;
            assign leaf_data[i] = '0;
        end
    end

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        oaids_pick #(
            .N(GRP)
        ) u_pick (
            .aclk    (aclk),
            .hit_in  (leaf_hit[g*GRP +: GRP]),
            .pos_in  (leaf_pos[g*GRP +: GRP]),
            .data_in (leaf_data[g*GRP +: GRP]),
            .hit_out (grp_hit[g]),
            .pos_out (grp_pos[g]),
            .data_out(grp_data[g])
        );
    end

    oaids_pick #(
        .N(NGRP)
    ) u_pick_final (
        .aclk    (aclk),
        .hit_in  (grp_hit),
        .pos_in  (grp_pos),
        .data_in (grp_data),
        .hit_out (fin_hit),
        .pos_out (fin_pos),
        .data_out(fin_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_rval_reg, out_fpos_reg};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= POS_W'(DEPTH))
        else $error("element count above capacity");

    a_count_when_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == ST_CELL))
        else $error("element count changed outside the cell step");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_load) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("result load did not present a transfer");

    a_found_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && req_mode_reg == MODE_SEARCH && fin_hit)
        |-> (fin_pos != '0 && fin_pos <= count_reg))
        else $error("search hit outside the stored elements");
`endif

endmodule

>>> rtl/core/oaids_cell.sv
module oaids_cell
    import oaids_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data_out,
    output logic              match_out
);

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic              match_reg;

    // An insert pulls from the lower neighbor, a delete from the upper one.
    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            if (ctrl.shift_up) begin
                if (IDX > ctrl.boundary) begin
                    data_reg <= left_data;
                end else if (IDX == ctrl.boundary) begin
                    data_reg <= ctrl.key;
                end
            end else if (ctrl.shift_down && IDX >= ctrl.boundary) begin
                data_reg <= right_data;
            end
            match_reg <= (ctrl.by_value && data_reg == ctrl.key && IDX < ctrl.count)
                      || (ctrl.by_index && IDX == ctrl.boundary);
        end
    end

    assign data_out  = data_reg;
    assign match_out = match_reg;

endmodule

>>> rtl/core/oaids_pick.sv
module oaids_pick
    import oaids_pkg::*;
#(
    parameter int N = 8
) (
    input  logic              aclk,
    input  logic              hit_in  [N],
    input  logic [POS_W-1:0]  pos_in  [N],
    input  logic [DATA_W-1:0] data_in [N],
    output logic              hit_out,
    output logic [POS_W-1:0]  pos_out,
    output logic [DATA_W-1:0] data_out
);

    logic              hit_c;
    logic [POS_W-1:0]  pos_c;
    logic [DATA_W-1:0] data_c;
    logic              hit_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] data_reg;

    // The lowest hitting input wins.
    always_comb begin
        hit_c  = 1'b0;
        pos_c  = '0;
        data_c = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (hit_in[i]) begin
                hit_c  = 1'b1;
                pos_c  = pos_in[i];
                data_c = data_in[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg  <= hit_c;
        pos_reg  <= pos_c;
        data_reg <= data_c;
    end

    assign hit_out  = hit_reg;
    assign pos_out  = pos_reg;
    assign data_out = data_reg;

endmodule

>>> sim/ordered_array_insert_delete_search_tb.sv
`timescale 1ns / 100ps

module ordered_array_insert_delete_search_tb;
    import oaids_pkg::*;

    // The list size matches the block's default so that full-list behavior is reachable.
    localparam int LIST_DEPTH = 64;

    // This is one result as the scoreboard expects it.
    // The fields follow the m_tuser and m_tdata layout.
    typedef struct {
        status_t     status;
        logic [6:0]  found_position;
        logic [31:0] read_value;
        logic [6:0]  element_count;
    } list_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;   // mode
    logic [39:0] s_tdata;   // position [6:0], value [38:7], zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;   // status
    logic [47:0] m_tdata;   // found_position [6:0], read_value [38:7], element_count [45:39]

    // The testbench keeps its own copy of the list contents and the element count.
    logic [31:0]  model_vals [LIST_DEPTH];
    int           model_count;
    list_result_t pending_results [$];
    int           error_count;
    bit           idle_enabled;

    ordered_array_insert_delete_search #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser (m_tuser),
        .m_tdata (m_tdata)
    );

    // The clock period is 4 ns. The clock spends 2 ns low and then 2 ns high.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // This function applies one request to the list copy and returns the result that the block
    // should give. Out-of-range positions leave the list unchanged. For an insert, the position
    // check comes before the full check.
    function automatic list_result_t apply_list_request(mode_t mode, logic [6:0] pos,
                                                        logic [31:0] val);
        list_result_t r;
        int p;
        int k;
        p                = int'(pos);
        r.status         = STATUS_OK;
        r.found_position = '0;
        r.read_value     = '0;
        case (mode)
            MODE_READ: begin
                if (p >= 1 && p <= model_count)
                    r.read_value = model_vals[p-1];
                else
                    r.status = STATUS_INVALID;
            end
            MODE_INSERT: begin
                if (p < 1 || p > model_count + 1) begin
                    r.status = STATUS_INVALID;
                end else if (model_count >= LIST_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    for (k = model_count; k >= p; k--)
                        model_vals[k] = model_vals[k-1];
                    model_vals[p-1] = val;
                    model_count++;
                end
            end
            MODE_DELETE: begin
                if (p >= 1 && p <= model_count) begin
                    for (k = p - 1; k + 1 < model_count; k++)
                        model_vals[k] = model_vals[k+1];
                    model_count--;
                end else begin
                    r.status = STATUS_INVALID;
                end
            end
            default: begin
                // A search compares only the occupied positions and reports the first match.
                r.status = STATUS_NOT_FOUND;
                for (k = 0; k < model_count; k++) begin
                    if (model_vals[k] == val) begin
                        r.status         = STATUS_OK;
                        r.found_position = 7'(k + 1);
                        break;
                    end
                end
            end
        endcase
        r.element_count = 7'(model_count);
        return r;
    endfunction

    // This task offers one request on the input channel. Before the request it sometimes lowers
    // s_tvalid. It then holds the request until a transfer takes place. The expected result is
    // computed at the edge that accepts the transfer, so the queue of expected results stays in
    // transfer order.
    task automatic send_request(input mode_t mode, input logic [6:0] pos, input logic [31:0] val);
        int gap;
        if (idle_enabled && $urandom_range(0, 99) < 14) begin
            gap = $urandom_range(1, 6);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {1'b0, val, pos};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_list_request(mode, pos, val));
    endtask

    // The sender stops here until every expected result has arrived.
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // The value source mixes stored elements, which give search hits and duplicates, with a few
    // corner values and fully random words.
    function automatic logic [31:0] pick_value();
        logic [31:0] corners [6];
        int sel;
        corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005};
        sel = $urandom_range(0, 9);
        if (sel < 4 && model_count > 0)
            return model_vals[$urandom_range(0, model_count - 1)];
        else if (sel < 6)
            return corners[$urandom_range(0, 5)];
        else
            return $urandom;
    endfunction

    // This test covers requests on an empty list. Every position is out of range, and a search
    // always misses.
    task automatic test_empty_list();
        send_request(MODE_READ,   7'd1, 32'h0);
        send_request(MODE_READ,   7'd0, 32'h0);
        send_request(MODE_DELETE, 7'd1, 32'h0);
        send_request(MODE_SEARCH, 7'd0, 32'h0);
        send_request(MODE_INSERT, 7'd0, 32'h1234_5678);
        send_request(MODE_INSERT, 7'd2, 32'h1234_5678);
    endtask

    // This test uses the extreme values and positions. It also checks that a search returns the
    // first of two equal entries, and it deletes from the middle, the end and the head.
    task automatic test_edge_values();
        send_request(MODE_INSERT, 7'd1,   32'h8000_0000);
        send_request(MODE_INSERT, 7'd2,   32'h7FFF_FFFF);
        send_request(MODE_INSERT, 7'd1,   32'h0000_0000);
        send_request(MODE_INSERT, 7'd4,   32'hFFFF_FFFF);
        send_request(MODE_INSERT, 7'd3,   32'h7FFF_FFFF);
        send_request(MODE_READ,   7'd1,   32'hFFFF_FFFF);
        send_request(MODE_READ,   7'd5,   32'h0);
        send_request(MODE_READ,   7'd6,   32'h0);
        send_request(MODE_SEARCH, 7'd127, 32'h7FFF_FFFF);
        send_request(MODE_SEARCH, 7'd0,   32'h1234_5678);
        send_request(MODE_INSERT, 7'd127, 32'h5555_AAAA);
        send_request(MODE_DELETE, 7'd127, 32'h0);
        send_request(MODE_READ,   7'd127, 32'h0);
        send_request(MODE_DELETE, 7'd3,   32'h0);
        send_request(MODE_DELETE, 7'd4,   32'h0);
        send_request(MODE_DELETE, 7'd1,   32'h0);
        wait_for_results();
    endtask

    // This test fills the list to its limit. On a full list, an insert at a valid position reports
    // a full list. A position beyond count + 1 still reports an invalid position.
    task automatic test_full_list();
        while (model_count < LIST_DEPTH)
            send_request(MODE_INSERT, 7'($urandom_range(1, model_count + 1)), pick_value());
        send_request(MODE_INSERT, 7'd1,  32'hDEAD_BEEF);
        send_request(MODE_INSERT, 7'(LIST_DEPTH + 1), 32'hDEAD_BEEF);
        send_request(MODE_INSERT, 7'(LIST_DEPTH + 2), 32'hDEAD_BEEF);
        send_request(MODE_READ,   7'(LIST_DEPTH),     32'h0);
        send_request(MODE_READ,   7'(LIST_DEPTH + 1), 32'h0);
        send_request(MODE_SEARCH, 7'd0, model_vals[LIST_DEPTH-1]);
        send_request(MODE_DELETE, 7'(LIST_DEPTH), 32'h0);
        send_request(MODE_DELETE, 7'd1, 32'h0);
        wait_for_results();
    endtask

    // This test sends random requests. The insert share sets the drift of the count, so that one
    // phase fills the list and another empties it. Most positions fall inside the range that is
    // valid for the request kind.
    task automatic test_random_mix(input int n_items, input int insert_pct);
        int    i;
        int    r;
        mode_t mode;
        int    hi;
        logic [6:0] pos;
        for (i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20)
                mode = MODE_READ;
            else if (r < 40)
                mode = MODE_SEARCH;
            else if (r < 40 + insert_pct)
                mode = MODE_INSERT;
            else
                mode = MODE_DELETE;
            hi = (mode == MODE_INSERT) ? model_count + 1 : model_count;
            if (hi >= 1 && $urandom_range(0, 99) < 85)
                pos = 7'($urandom_range(1, hi));
            else
                pos = 7'($urandom_range(0, 127));
            send_request(mode, pos, pick_value());
        end
        wait_for_results();
    endtask

    // This process checks each result transfer against the oldest expectation in the queue.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[6:0] !== want.found_position) begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, m_tdata[6:0]);
                    error_count++;
                end
                if (m_tdata[38:7] !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           $signed(want.read_value), $signed(m_tdata[38:7]));
                    error_count++;
                end
                if (m_tdata[45:39] !== want.element_count) begin
                    $error("element_count: expected %0d, got %0d",
                           want.element_count, m_tdata[45:39]);
                    error_count++;
                end
                if (m_tdata[47:46] !== 2'b00) begin
                    $error("m_tdata fill: expected 0, got %0d", m_tdata[47:46]);
                    error_count++;
                end
            end
        end
    end

    // The result side lowers m_tready with a chance of 14 in a hundred while idling is enabled.
    always @(negedge aclk) begin
        if (idle_enabled)
            m_tready = ($urandom_range(0, 99) >= 14);
        else
            m_tready = 1'b1;
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = MODE_READ;
        s_tdata      = '0;
        error_count  = 0;
        idle_enabled = 1'b1;
        model_count  = 0;
        foreach (model_vals[k])
            model_vals[k] = '0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_list();
        test_edge_values();
        test_full_list();
        test_random_mix(300, 45);
        test_random_mix(250, 15);
        // For this phase neither side idles, so requests follow each other as fast as the block
        // accepts them.
        idle_enabled = 1'b0;
        test_random_mix(200, 30);
        idle_enabled = 1'b1;
        test_random_mix(110, 32);

        // All requests have been sent. A final wait catches any stray result transfer.
        wait_for_results();
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // The time limit is 2 ms, which is far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
